// File: sv/npcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  localparam int COMP_W  = 8;
  localparam int QCOMP_W = 5;
  localparam int COLOR_W = 15;
  localparam int ENTRY_W = 3 * COMP_W;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = 18;
  localparam int OIDX_W  = 8;
  localparam int CFG_W   = 9;

  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

  // input beat layout
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_RED_LSB   = 8;
  localparam int IN_GREEN_LSB = 16;
  localparam int IN_BLUE_LSB  = 24;
  localparam int IN_COLOR_LSB = 32;
  localparam int IN_TDATA_W   = 48;

  // output beat layout
  localparam int OUT_COLOR_LSB = 0;
  localparam int OUT_IDX_LSB   = 15;
  localparam int OUT_DIST_LSB  = 23;
  localparam int OUT_TDATA_W   = 48;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] e,
                                              input logic [QCOMP_W-1:0] q);
    logic [COMP_W-1:0] qe;
    logic [COMP_W-1:0] d;
    qe = COMP_W'(q);
    d  = (e >= qe) ? (e - qe) : (qe - e);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

// File: sv/nearest_palette_color_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette color search. A beat with tuser = write stores one 8-bit RGB
// palette entry (no output beat); a beat with tuser = query takes an RGB555
// color and returns the lowest palette index at minimal squared distance.
// A query scans entries 0 .. N-1 (N = palette_count, 0 read as 1, clipped to
// PALETTE_SIZE) one per cycle through the single read port of the palette RAM.
// The input is held off from the query beat until its result is loaded into
// the output register, so a new query is taken only after the last is done;
// an exact match ends the scan early. A finished result waits in the
// output register while the next beat is taken; a second finished result waits
// until the first has left. Writes and scan reads never share a cycle.
module nearest_palette_color_search_unit
  import npcs_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] entry_index, [15:8] entry_red, [23:16] entry_green,
  // [31:24] entry_blue, [46:32] color_code, [47] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [14:0] query_color, [22:15] nearest_index, [40:23] min_distance, [47:41] zero
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_W-1:0]       cfg_data_i
);

  localparam int IDX_W = $clog2(PALETTE_SIZE);
  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]  palette_count_q;
  logic [IDX_W-1:0]  addr_q;
  logic [IDX_W-1:0]  last_q;
  logic              issue_q;
  logic              v1_q;
  logic              v2_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [IDX_W-1:0]  idx2_q;
  logic [SQ_W-1:0]   sq_r_q;
  logic [SQ_W-1:0]   sq_g_q;
  logic [SQ_W-1:0]   sq_b_q;
  logic [DIST_W-1:0] best_d_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [COLOR_W-1:0] qcolor_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic               in_fire;
  logic               is_query;
  logic               wr_en;
  logic               rd_en;
  logic [COLOR_W-1:0] color_in;
  logic [IDX_W-1:0]   last_d;
  logic [CMP_W-1:0]   cnt_ext;
  logic [DIST_W-1:0]  cand_dist;
  logic               better;
  logic               finish;
  logic               out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tdata  = out_data_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign is_query = (action_e'(s_axis_tuser) == ACT_QUERY);
  assign color_in = s_axis_tdata[IN_COLOR_LSB +: COLOR_W];
  assign wr_en    = in_fire && !is_query &&
                    ({24'd0, s_axis_tdata[IN_IDX_LSB +: OIDX_W]} < PALETTE_SIZE);
  assign wdata    = {s_axis_tdata[IN_RED_LSB +: COMP_W],
                     s_axis_tdata[IN_GREEN_LSB +: COMP_W],
                     s_axis_tdata[IN_BLUE_LSB +: COMP_W]};
  assign rd_en    = (state_q == ST_SCAN) && issue_q;

  always_comb begin
    cnt_ext = CMP_W'(palette_count_q);
    if (cnt_ext == '0) begin
      last_d = '0;
    end else if (cnt_ext > CMP_W'(PALETTE_SIZE)) begin
      last_d = IDX_W'(PALETTE_SIZE - 1);
    end else begin
      last_d = IDX_W'(cnt_ext - CMP_W'(1));
    end
  end

  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  assign better    = v2_q && (cand_dist < best_d_q);
  assign finish    = v2_q && ((cand_dist == '0) || (idx2_q == last_q));
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  npcs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PALETTE_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(IDX_W'(s_axis_tdata[IN_IDX_LSB +: OIDX_W])),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      palette_count_q <= CFG_W'(1);
      issue_q         <= 1'b0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        palette_count_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && is_query) begin
            issue_q <= 1'b1;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            issue_q <= 1'b0;
            v1_q    <= 1'b0;
            v2_q    <= 1'b0;
            state_q <= ST_DONE;
          end else begin
            v1_q <= rd_en;
            v2_q <= v1_q;
            if (issue_q && (addr_q == last_q)) begin
              issue_q <= 1'b0;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire && is_query) begin
      addr_q     <= '0;
      last_q     <= last_d;
      best_d_q   <= '1;
      best_idx_q <= '0;
      qcolor_q   <= color_in;
    end
    if (rd_en) begin
      addr_q <= addr_q + IDX_W'(1);
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    sq_r_q <= sq_diff(rdata[2*COMP_W +: COMP_W], qcolor_q[2*QCOMP_W +: QCOMP_W]);
    sq_g_q <= sq_diff(rdata[COMP_W +: COMP_W], qcolor_q[QCOMP_W +: QCOMP_W]);
    sq_b_q <= sq_diff(rdata[0 +: COMP_W], qcolor_q[0 +: QCOMP_W]);
    if (state_q == ST_SCAN && better) begin
      best_d_q   <= cand_dist;
      best_idx_q <= idx2_q;
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= OUT_TDATA_W'({best_d_q, OIDX_W'(best_idx_q), qcolor_q});
    end
  end

endmodule

`default_nettype wire

// File: sv/npcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/npcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module npcs_checker
  import npcs_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   cfg_valid_i,
  input wire logic                   cfg_ready_o,
  input wire logic [CFG_W-1:0]       cfg_data_i
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DIST_LSB +: DIST_W] <= MAX_DIST)
    else $error("distance out of range");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_e'(s_axis_tuser) == ACT_QUERY) |=> !s_axis_tready)
    else $error("ready during query scan");

  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_e'(s_axis_tuser) == ACT_WRITE) |=> s_axis_tready)
    else $error("write beat stalled input");

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .cfg_data_i   (cfg_data_i)
);

`default_nettype wire
